[rtl/sdns_pkg.sv]
// Shared types, constants and helpers of the sorted directory name search.
package sdns_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int NAME_BYTES  = 24;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int KEY_W       = 192;
	localparam int APB_ADDR_W  = 3;

	// action codes
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_FIND   = 2'd1;
	localparam logic [1:0] ACT_SELECT = 2'd2;

	// status codes
	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_MISS   = 2'd1;
	localparam logic [1:0] ST_LOADED = 2'd2;

	// register word indexes
	localparam logic REG_BASE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic [31:0]      archive_base;
		logic [CNT_W-1:0] file_count;
	} cfg_t;

	typedef struct packed {
		logic [63:0] name_high;
		logic [63:0] name_middle;
		logic [63:0] name_low;
		logic [31:0] offset;
		logic [31:0] size;
	} entry_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic [IDX_W-1:0] addr;
		entry_t           wdata;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [IDX_W-1:0] found_index;
		logic [31:0]      data_address;
		logic [31:0]      file_size;
		logic [63:0]      found_name_high;
		logic [63:0]      found_name_middle;
		logic [63:0]      found_name_low;
	} result_t;

	// Keep the name bytes that fall into 64-bit word w (0 high, 1 middle, 2 low).
	function automatic logic [63:0] name_mask(input int w);
		int keep;
		keep = NAME_BYTES - 8 * w;
		if (keep <= 0) begin
			return 64'd0;
		end else if (keep >= 8) begin
			return ~64'd0;
		end
		return ~64'd0 << (64 - 8 * keep);
	endfunction

endpackage

[rtl/sdns_in_if.sv]
// Request channel: action, index, name key and load payload.
interface sdns_in_if;
	import sdns_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       action;
	logic [IDX_W-1:0] entry_index;
	logic [63:0]      name_high;
	logic [63:0]      name_middle;
	logic [63:0]      name_low;
	logic [31:0]      load_offset;
	logic [31:0]      load_size;

	modport source (
		output valid, action, entry_index, name_high, name_middle, name_low,
		output load_offset, load_size,
		input  ready
	);
	modport sink (
		input  valid, action, entry_index, name_high, name_middle, name_low,
		input  load_offset, load_size,
		output ready
	);
endinterface

[rtl/sdns_out_if.sv]
// Response channel: status and selected entry fields.
interface sdns_out_if;
	import sdns_pkg::*;

	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] found_index;
	logic [31:0]      data_address;
	logic [31:0]      file_size;
	logic [63:0]      found_name_high;
	logic [63:0]      found_name_middle;
	logic [63:0]      found_name_low;

	modport source (
		output valid, status, found_index, data_address, file_size,
		output found_name_high, found_name_middle, found_name_low,
		input  ready
	);
	modport sink (
		input  valid, status, found_index, data_address, file_size,
		input  found_name_high, found_name_middle, found_name_low,
		output ready
	);
endinterface

[rtl/sdns_dir_mem.sv]
// Directory entry memory: one access port, registered read data.
module sdns_dir_mem (
	input  logic              clk,
	input  sdns_pkg::mem_req_t req,
	output sdns_pkg::entry_t   rdata
);
	import sdns_pkg::*;

	entry_t dir_mem [MAX_ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			dir_mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_q <= dir_mem[req.addr];
		end
	end

	assign rdata = rd_q;

endmodule

[rtl/sdns_cfg.sv]
// APB register file: archive base and file count.
module sdns_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sdns_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output sdns_pkg::cfg_t                 cfg
);
	import sdns_pkg::*;

	logic [31:0]      base_q;
	logic [CNT_W-1:0] count_q;
	logic             reg_idx;
	logic             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BASE:  base_q  <= pwdata;
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				default:   base_q  <= base_q;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BASE:  prdata = base_q;
			REG_COUNT: prdata = {{(32 - CNT_W){1'b0}}, count_q};
			default:   prdata = '0;
		endcase
	end

	assign cfg.archive_base = base_q;
	assign cfg.file_count   = count_q;

endmodule

[rtl/sdns_ctrl.sv]
// Sequencer: load, binary search and select over the entry memory, result register.
module sdns_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  sdns_pkg::cfg_t     cfg,
	sdns_in_if.sink            req,
	sdns_out_if.source         rsp,
	output sdns_pkg::mem_req_t mem_req,
	input  sdns_pkg::entry_t   mem_rdata
);
	import sdns_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_PROBE = 5'b00010,
		S_CMP   = 5'b00100,
		S_SEL   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] mid_q;
	logic [IDX_W-1:0] sel_q;
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [KEY_W-1:0] key_q;
	logic [1:0]       fin_status_q;
	logic             rsp_valid_q;
	result_t          rsp_q;

	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   mid_sum;
	logic [IDX_W-1:0] mid;
	logic [KEY_W-1:0] key_in;
	logic [KEY_W-1:0] ent_key;
	logic [IDX_W-1:0] hit_idx;
	logic             accept;
	logic             window_open;
	logic             key_eq;
	logic             key_gt;
	logic             out_free;
	logic             emit_hit;
	logic             emit_fin;
	logic             sel_in_range;

	assign count = (cfg.file_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
		: cfg.file_count;

	// mid = (left + right) / 2 with right = hi - 1; only used while lo < hi
	assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
	assign mid         = mid_sum[IDX_W:1];
	assign window_open = lo_q < hi_q;

	assign key_in  = {req.name_high & name_mask(0), req.name_middle & name_mask(1),
		req.name_low & name_mask(2)};
	assign ent_key = {mem_rdata.name_high, mem_rdata.name_middle, mem_rdata.name_low};
	assign key_eq  = key_q == ent_key;
	assign key_gt  = key_q > ent_key;

	assign req.ready    = state_q == S_IDLE;
	assign accept       = req.valid && (state_q == S_IDLE);
	assign sel_in_range = {1'b0, req.entry_index} < count;
	assign out_free     = !rsp_valid_q || rsp.ready;
	assign hit_idx      = (state_q == S_CMP) ? mid_q : idx_q;
	assign emit_hit     = out_free && (((state_q == S_CMP) && key_eq) || (state_q == S_SEL));
	assign emit_fin     = out_free && (state_q == S_FIN);

	// memory port
	always_comb begin
		mem_req.wdata.name_high   = key_in[KEY_W-1 -: 64];
		mem_req.wdata.name_middle = key_in[KEY_W-65 -: 64];
		mem_req.wdata.name_low    = key_in[63:0];
		mem_req.wdata.offset      = req.load_offset;
		mem_req.wdata.size        = req.load_size;
		mem_req.wr_en             = accept && (req.action == ACT_LOAD);
		mem_req.rd_en             = 1'b0;
		mem_req.addr              = req.entry_index;
		if (accept && (req.action == ACT_SELECT) && sel_in_range) begin
			mem_req.rd_en = 1'b1;
		end
		if ((state_q == S_PROBE) && window_open) begin
			mem_req.rd_en = 1'b1;
			mem_req.addr  = mid;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_FIND:   state_d = S_PROBE;
						ACT_SELECT: state_d = sel_in_range ? S_SEL : S_FIN;
						default:    state_d = S_FIN;
					endcase
				end
			end
			S_PROBE: state_d = window_open ? S_CMP : S_FIN;
			S_CMP: begin
				if (!key_eq) begin
					state_d = S_PROBE;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_SEL: if (out_free) state_d = S_IDLE;
			S_FIN: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			sel_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit_hit || emit_fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (emit_hit) begin
				sel_q <= hit_idx;
			end
		end
	end

	// search window, key and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q        <= req.entry_index;
			key_q        <= key_in;
			lo_q         <= '0;
			hi_q         <= count;
			fin_status_q <= (req.action == ACT_LOAD) ? ST_LOADED : ST_MISS;
		end
		if ((state_q == S_PROBE) && window_open) begin
			mid_q <= mid;
		end
		if ((state_q == S_CMP) && !key_eq) begin
			if (key_gt) begin
				lo_q <= {1'b0, mid_q} + CNT_W'(1);
			end else begin
				hi_q <= {1'b0, mid_q};
			end
		end
		if (emit_hit) begin
			rsp_q.status            <= ST_FOUND;
			rsp_q.found_index       <= hit_idx;
			rsp_q.data_address      <= cfg.archive_base + mem_rdata.offset;
			rsp_q.file_size         <= mem_rdata.size;
			rsp_q.found_name_high   <= mem_rdata.name_high;
			rsp_q.found_name_middle <= mem_rdata.name_middle;
			rsp_q.found_name_low    <= mem_rdata.name_low;
		end else if (emit_fin) begin
			rsp_q.status            <= fin_status_q;
			rsp_q.found_index       <= '0;
			rsp_q.data_address      <= '0;
			rsp_q.file_size         <= '0;
			rsp_q.found_name_high   <= '0;
			rsp_q.found_name_middle <= '0;
			rsp_q.found_name_low    <= '0;
		end
	end

	assign rsp.valid             = rsp_valid_q;
	assign rsp.status            = rsp_q.status;
	assign rsp.found_index       = rsp_q.found_index;
	assign rsp.data_address      = rsp_q.data_address;
	assign rsp.file_size         = rsp_q.file_size;
	assign rsp.found_name_high   = rsp_q.found_name_high;
	assign rsp.found_name_middle = rsp_q.found_name_middle;
	assign rsp.found_name_low    = rsp_q.found_name_low;

	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("entry memory written and read in one cycle");

	a_probe_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> (lo_q <= {1'b0, mid_q}) && ({1'b0, mid_q} < hi_q))
		else $error("probe index outside search window");

	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PROBE |-> hi_q <= count)
		else $error("search bound beyond file count");

	a_hit_selects: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status == ST_FOUND) |-> rsp_q.found_index == sel_q)
		else $error("reported hit differs from selected entry");

	a_hit_from_probe: assert property (@(posedge clk) disable iff (!arst_n)
		emit_hit |=> rsp_valid_q && (rsp_q.status == ST_FOUND))
		else $error("hit not registered as found");

endmodule

[rtl/sorted_directory_name_search.sv]
// Top level of the sorted directory name search.
//
//  channel  dir   handshake              payload
//  req      in    valid/ready            action, entry_index, name_*, load_offset, load_size
//  rsp      out   valid/ready            status, found_index, data_address, file_size, found_name_*
//  apb      in    psel/penable/pready    paddr, pwdata, prdata (base at 0x0, file count at 0x4)
//
// Load and select pass through a single response state; a find alternates a probe state
// and a compare state until a hit or an empty window. Each probe is one memory read and one 192-bit
// compare; 256 entries need up to 9 probes. A miss ends through the finish state.
// One request is in flight at a time; the result register frees the search as soon as
// the beat is written. A full result register holds the sequencer in its last state.
// Reset clears control, the APB registers and the selection; entry memory is not cleared.
module sorted_directory_name_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sdns_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	sdns_in_if.sink                         req,
	sdns_out_if.source                      rsp
);
	import sdns_pkg::*;

	cfg_t     cfg;
	mem_req_t mem_req;
	entry_t   mem_rdata;

	sdns_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sdns_dir_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	sdns_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req       (req),
		.rsp       (rsp),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule
